// ----- design/stk_pkg.sv -----
`default_nettype none

package stk_pkg;

    localparam int FUNC_W  = 3;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 5;

    // Pop or peek on an empty stack answers all ones.
    localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH        = 3'd0,
        FN_PUSH_UNIQUE = 3'd1,
        FN_POP         = 3'd2,
        FN_REMOVE      = 3'd3,
        FN_PEEK        = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_DUP       = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
        logic               now_empty;
        logic [COUNT_W-1:0] count;
    } res_t;

endpackage

`default_nettype wire

// ----- design/stk_if.sv -----
`default_nettype none

interface stk_req_if;
    logic                                valid;
    logic                                ready;
    logic [stk_pkg::FUNC_W-1:0]          func;
    logic signed [stk_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

interface stk_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [stk_pkg::VALUE_W-1:0]  result_value;
    logic [stk_pkg::STAT_W-1:0]          status;
    logic                                now_empty;
    logic [stk_pkg::COUNT_W-1:0]         count;

    modport source (output valid, output result_value, output status, output now_empty,
                    output count, input ready);
    modport sink (input valid, input result_value, input status, input now_empty,
                  input count, output ready);
endinterface

`default_nettype wire

// ----- design/stk_ram.sv -----
`default_nettype none

module stk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/stk_ctrl.sv -----
`default_nettype none

module stk_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       req_valid,
    output logic                                            req_ready,
    input  wire logic [stk_pkg::FUNC_W-1:0]                 req_func,
    input  wire logic [stk_pkg::VALUE_W-1:0]                req_value,
    output logic                                            res_valid,
    input  wire logic                                       res_ready,
    output stk_pkg::res_t                                   res,
    output logic                                            mem_we,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]      mem_waddr,
    output logic [stk_pkg::VALUE_W-1:0]                     mem_wdata,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]      mem_raddr,
    input  wire logic [stk_pkg::VALUE_W-1:0]                mem_rdata
);

    import stk_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      left_reg, left_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]      sh_idx_reg, sh_idx_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    status_t            status_reg, status_next;

    logic [AW-1:0]      top_idx;
    logic               is_full;
    logic               is_empty;
    logic               hit;

    assign top_idx  = AW'(count_reg - CW'(1));
    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);
    // The single comparator: the word read last cycle against the searched value.
    assign hit      = cmp_valid_reg && (mem_rdata == value_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        value_reg     <= value_next;
        rd_ptr_reg    <= rd_ptr_next;
        left_reg      <= left_next;
        cmp_idx_reg   <= cmp_idx_next;
        sh_idx_reg    <= sh_idx_next;
        res_value_reg <= res_value_next;
        status_reg    <= status_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        left_next      = left_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        sh_idx_next    = sh_idx_reg;
        res_value_next = res_value_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_wdata      = value_reg;
        mem_raddr      = top_idx;
        req_ready      = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    func_next      = func_t'(req_func);
                    value_next     = req_value;
                    res_value_next = '0;
                    status_next    = ST_OK;
                    state_next     = S_FINISH;
                    case (func_t'(req_func))
                        FN_PUSH:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_wdata  = req_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FN_PUSH_UNIQUE, FN_REMOVE:
                        begin
                            if (!is_empty)
                            begin
                                rd_ptr_next    = top_idx;
                                left_next      = count_reg;
                                cmp_valid_next = 1'b0;
                                state_next     = S_SCAN;
                            end
                            else if (func_t'(req_func) == FN_PUSH_UNIQUE)
                            begin
                                // An empty store has room.
                                mem_we     = 1'b1;
                                mem_wdata  = req_value;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        FN_POP, FN_PEEK:
                        begin
                            if (is_empty)
                            begin
                                res_value_next = EMPTY_VALUE;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_READ:
            begin
                res_value_next = mem_rdata;
                if (func_reg == FN_POP)
                begin
                    count_next = count_reg - CW'(1);
                end
                state_next = S_FINISH;
            end

            S_SCAN:
            begin
                // Reads run one ahead of the compare, from the top down.
                if (hit)
                begin
                    if (func_reg == FN_PUSH_UNIQUE)
                    begin
                        status_next = ST_DUP;
                        state_next  = S_FINISH;
                    end
                    else if ((CW'(cmp_idx_reg) + CW'(1)) < count_reg)
                    begin
                        mem_raddr   = cmp_idx_reg + AW'(1);
                        sh_idx_next = cmp_idx_reg;
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_FINISH;
                    end
                end
                else if (left_reg != '0)
                begin
                    mem_raddr      = rd_ptr_reg;
                    cmp_idx_next   = rd_ptr_reg;
                    cmp_valid_next = 1'b1;
                    rd_ptr_next    = rd_ptr_reg - AW'(1);
                    left_next      = left_reg - CW'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = S_FINISH;
                    if (func_reg == FN_PUSH_UNIQUE)
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                if (hit)
                begin
                    cmp_valid_next = 1'b0;
                end
            end

            S_SHIFT:
            begin
                // Move the entry above the gap down by one; the read runs two slots above the write.
                mem_we      = 1'b1;
                mem_waddr   = sh_idx_reg;
                mem_wdata   = mem_rdata;
                sh_idx_next = sh_idx_reg + AW'(1);
                if ((CW'(sh_idx_reg) + CW'(2)) < count_reg)
                begin
                    mem_raddr = sh_idx_reg + AW'(2);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.value     = res_value_reg;
    assign res.status    = status_reg;
    assign res.now_empty = is_empty;
    assign res.count     = COUNT_W'(count_reg);

endmodule

`default_nettype wire

// ----- design/stack_with_unique_push_and_remove.sv -----
// Push finishes straight from idle; pop and peek read the top entry first.
// Push unique and remove scan the store from the top, one compare per cycle
// on a single comparator, and remove then shifts each entry above the match
// down to close the gap. One item is in work at a time; the next can be
// accepted in the cycle after the result moves to the output register.
// Asynchronous active-low reset empties the stack; the store needs no clearing.
`default_nettype none

module stack_with_unique_push_and_remove #(
    parameter int DEPTH = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    stk_req_if.sink     req,
    stk_rsp_if.source   rsp
);

    import stk_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    res_t               res;
    logic               res_valid;
    logic               res_ready;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic               out_valid_reg;
    res_t               out_data_reg;

    stk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_func  (req.func),
        .req_value (req.value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    stk_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: the next item can be worked on while a result waits.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_data_reg.value;
    assign rsp.status       = out_data_reg.status;
    assign rsp.now_empty    = out_data_reg.now_empty;
    assign rsp.count        = out_data_reg.count;

endmodule

`default_nettype wire

// ----- design/stk_chk.sv -----
`default_nettype none

module stk_chk (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [stk_pkg::VALUE_W-1:0]   rsp_value,
    input wire logic [stk_pkg::STAT_W-1:0]    rsp_status,
    input wire logic                          rsp_now_empty,
    input wire logic [stk_pkg::COUNT_W-1:0]   rsp_count
);

    import stk_pkg::*;

    // Every item leaves the idle state on acceptance, so acceptance always drops ready.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready stayed high after an item was accepted");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
        else $error("result changed or vanished while stalled");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_now_empty |-> rsp_count == '0)
        else $error("empty flag set with a nonzero count");

    a_empty_answer: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY |-> rsp_value == EMPTY_VALUE && rsp_now_empty)
        else $error("empty status without the empty answer");

    a_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_DUP
            || rsp_status == ST_NOT_FOUND) |-> rsp_value == '0)
        else $error("a failed push or remove carried a value");

endmodule

bind stack_with_unique_push_and_remove stk_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_value     (rsp.result_value),
    .rsp_status    (rsp.status),
    .rsp_now_empty (rsp.now_empty),
    .rsp_count     (rsp.count)
);

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import stk_pkg::*;

    localparam int DEPTH       = 16;
    localparam int MAX_WAIT    = 12;
    localparam int HOLD_CYCLES = 220;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASES      = 21;
    localparam int PHASE_ITEMS = 49;

    // Codes 5 to 7 are not operations; the block must leave the stack alone.
    localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    stk_req_if req ();
    stk_rsp_if rsp ();

    stack_with_unique_push_and_remove #(
        .DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #10 clk = ~clk;

    cmd_t               cmds_waiting[$];
    res_t               outcomes_due[$];
    logic [VALUE_W-1:0] held[DEPTH];
    int                 held_cnt;
    logic [VALUE_W-1:0] word_pool[8];
    int                 errors = 0;
    int                 results_seen;
    int                 gap_left;
    int                 stall_left;
    int                 hold_left;
    int                 idle_cycles = 0;
    int                 draw;
    bit                 src_steady;
    bit                 snk_steady;
    cmd_t               nxt;
    res_t               want;

    function automatic int topmost_match(logic [VALUE_W-1:0] w);
        for (int i = held_cnt - 1; i >= 0; i--)
        begin
            if (held[i] == w)
                return i;
        end
        return -1;
    endfunction

    function automatic status_t push_word(logic [VALUE_W-1:0] w);
        if (held_cnt >= DEPTH)
            return ST_FULL;
        held[held_cnt] = w;
        held_cnt++;
        return ST_OK;
    endfunction

    // Applies one accepted item to the shadow stack and returns its result.
    function automatic res_t stack_outcome(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] w);
        res_t r;
        int   hit;
        r.value  = '0;
        r.status = ST_OK;
        case (f)
            FN_PUSH:
                r.status = push_word(w);
            FN_PUSH_UNIQUE:
                r.status = (topmost_match(w) >= 0) ? ST_DUP : push_word(w);
            FN_POP:
            begin
                if (held_cnt == 0)
                begin
                    r.value  = EMPTY_VALUE;
                    r.status = ST_EMPTY;
                end
                else
                begin
                    held_cnt--;
                    r.value = held[held_cnt];
                end
            end
            FN_REMOVE:
            begin
                hit = topmost_match(w);
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    for (int i = hit; i + 1 < held_cnt; i++)
                        held[i] = held[i + 1];
                    held_cnt--;
                end
            end
            FN_PEEK:
            begin
                if (held_cnt == 0)
                begin
                    r.value  = EMPTY_VALUE;
                    r.status = ST_EMPTY;
                end
                else
                    r.value = held[held_cnt - 1];
            end
            default:
                ;
        endcase
        r.now_empty = (held_cnt == 0);
        r.count     = COUNT_W'(held_cnt);
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] exp_val);
        $display("result %0d: %s is %h, expected %h", results_seen, what, got, exp_val);
        errors++;
    endtask

    task automatic queue_cmd(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] w);
        cmd_t c;
        c.func  = f;
        c.value = w;
        cmds_waiting.push_back(c);
    endtask

    // Small value pool so that duplicates and removals find matches often.
    function automatic cmd_t random_cmd(bit filling);
        cmd_t c;
        int   r;
        r = $urandom_range(0, 99);
        if (r < 3)
            c.func = FN_FIRST_UNUSED + FUNC_W'($urandom_range(0, 2));
        else if (r < (filling ? 38 : 23))
            c.func = FN_PUSH;
        else if (r < (filling ? 70 : 42))
            c.func = FN_PUSH_UNIQUE;
        else if (r < (filling ? 82 : 70))
            c.func = FN_POP;
        else if (r < 94)
            c.func = FN_REMOVE;
        else
            c.func = FN_PEEK;
        if ($urandom_range(0, 3) != 0)
            c.value = word_pool[$urandom_range(0, 7)];
        else
            c.value = $urandom();
        return c;
    endfunction

    function automatic int wait_cycles(bit steady);
        return steady ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    // Request driver: keeps valid up across back-to-back items.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.func  <= '0;
            req.value <= '0;
            gap_left  <= 0;
            held_cnt  = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                outcomes_due.push_back(stack_outcome(req.func, req.value));
            if (!req.valid || req.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left  <= gap_left - 1;
                    req.valid <= 1'b0;
                end
                else if (cmds_waiting.size() != 0)
                begin
                    nxt = cmds_waiting.pop_front();
                    req.func  <= nxt.func;
                    req.value <= nxt.value;
                    req.valid <= 1'b1;
                    gap_left  <= wait_cycles(src_steady);
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Result monitor and ready generator, including the long hold-offs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready    <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (outcomes_due.size() == 0)
                    flag_mismatch("unexpected result, value", rsp.result_value, '0);
                else
                begin
                    want = outcomes_due.pop_front();
                    if (rsp.result_value !== want.value)
                        flag_mismatch("result_value", rsp.result_value, want.value);
                    if (rsp.status !== want.status)
                        flag_mismatch("status", VALUE_W'(rsp.status),
                                      VALUE_W'(want.status));
                    if (rsp.now_empty !== want.now_empty)
                        flag_mismatch("now_empty", VALUE_W'(rsp.now_empty),
                                      VALUE_W'(want.now_empty));
                    if (rsp.count !== want.count)
                        flag_mismatch("count", VALUE_W'(rsp.count), VALUE_W'(want.count));
                end
                results_seen <= results_seen + 1;
                if (results_seen == 300 || results_seen == 700)
                begin
                    hold_left <= HOLD_CYCLES;
                    rsp.ready <= 1'b0;
                end
                else
                begin
                    draw = wait_cycles(snk_steady);
                    stall_left <= draw;
                    rsp.ready  <= (draw == 0);
                end
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp.ready <= 1'b0;
            end
            else if (stall_left > 1)
            begin
                stall_left <= stall_left - 1;
                rsp.ready  <= 1'b0;
            end
            else
            begin
                stall_left <= 0;
                rsp.ready  <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        src_steady  = 1'b0;
        snk_steady  = 1'b0;
        word_pool   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h5A5A_5A5A};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty stack cases and the unused codes.
        queue_cmd(FN_PEEK, 32'h0000_0000);
        queue_cmd(FN_POP, 32'hFFFF_FFFF);
        queue_cmd(FN_REMOVE, 32'h0000_0007);
        for (int k = 0; k < 3; k++)
            queue_cmd(FN_FIRST_UNUSED + FUNC_W'(k), 32'hA5A5_0000 + k);

        // Fill to the brim with the extreme words at the bottom.
        queue_cmd(FN_PUSH, 32'h7FFF_FFFF);
        queue_cmd(FN_PUSH, 32'h8000_0000);
        queue_cmd(FN_PUSH, 32'h0000_0000);
        queue_cmd(FN_PUSH_UNIQUE, 32'hFFFF_FFFF);
        for (int k = 4; k < DEPTH; k++)
            queue_cmd((k % 2 != 0) ? FN_PUSH_UNIQUE : FN_PUSH,
                      (k * 32'h0101_0101) ^ 32'h5A5A_0000);

        // Full store: plain push, duplicate, and a new word that cannot fit.
        queue_cmd(FN_PUSH, 32'h0000_0001);
        queue_cmd(FN_PUSH_UNIQUE, 32'h0000_0000);
        queue_cmd(FN_PUSH_UNIQUE, 32'h1234_5678);
        // Removing the bottom entry shifts every entry above it down.
        queue_cmd(FN_REMOVE, 32'h7FFF_FFFF);
        queue_cmd(FN_PEEK, 32'h0000_0000);
        queue_cmd(FN_REMOVE, 32'h0BAD_F00D);
        queue_cmd(FN_PUSH_UNIQUE, 32'hAAAA_AAAA);

        while (cmds_waiting.size() != 0)
            @(negedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            @(negedge clk);
            src_steady = ($urandom_range(0, 3) == 0);
            snk_steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
                cmds_waiting.push_back(random_cmd(p % 2 == 0));
            while (cmds_waiting.size() != 0)
                @(negedge clk);
        end

        while (outcomes_due.size() != 0 || req.valid)
            @(negedge clk);
        repeat (60) @(negedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
